/* rtl/core/hcr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared types and constants for the Harris corner response core.
// ----------------------------------------------------------------------------
package hcr_pkg;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int GRAD_W  = 11;
    localparam int RESP_W  = 48;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int K_W     = 15;
    localparam int CFG_W   = 15;
    localparam int CIDX_W  = 2;

    // Geometry
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_SIZE      = 5;

    // Register reset values
    localparam logic [10:0]  WIDTH_RST  = 11'd640;
    localparam logic [12:0]  HEIGHT_RST = 13'd480;
    localparam logic [K_W-1:0] K_RST    = 15'd3932;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COEF_K       = 2'd2;

    // Per-beat sideband that travels down the pipeline
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } meta_t;

endpackage

/* rtl/core/hcr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/hcr_grad.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_grad
// Raster counters, pixel line memory, Sobel gradients, gradient line memory
// and the 3x3 gradient window.
// ----------------------------------------------------------------------------
module hcr_grad #(
    parameter int MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [hcr_pkg::PIX_W-1:0]           pixel,
    input  logic                                frame_start,
    input  logic [10:0]                         image_width,
    input  logic [hcr_pkg::SIZE_W-1:0]          image_height,
    output hcr_pkg::meta_t                      meta_out,
    output logic signed [hcr_pkg::GRAD_W-1:0]   win_gx [9],
    output logic signed [hcr_pkg::GRAD_W-1:0]   win_gy [9]
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = hcr_pkg::PIX_W;
    localparam int GW = hcr_pkg::GRAD_W;
    localparam int SW = hcr_pkg::SIZE_W;

    // Clamped frame geometry
    logic [SW-1:0] w_eff, h_eff;

    always_comb
    begin
        if (SW'(image_width) < SW'(hcr_pkg::MIN_SIZE))
            w_eff = SW'(hcr_pkg::MIN_SIZE);
        else if (SW'(image_width) > SW'(MAX_WIDTH))
            w_eff = SW'(MAX_WIDTH);
        else
            w_eff = SW'(image_width);
        if (image_height < SW'(hcr_pkg::MIN_SIZE))
            h_eff = SW'(hcr_pkg::MIN_SIZE);
        else if (image_height > SW'(hcr_pkg::MAX_HEIGHT))
            h_eff = SW'(hcr_pkg::MAX_HEIGHT);
        else
            h_eff = image_height;
    end

    // Stage 0: position of the incoming beat, pixel line read
    logic [AW-1:0]                col_reg, col_next, c0;
    logic [hcr_pkg::ROW_W-1:0]    row_reg, row_next, r0;
    logic                         acc, last0, hit0;

    // Stage 1 registers
    logic                         s1_valid_reg;
    logic [PW-1:0]                s1_px_reg;
    logic [AW-1:0]                s1_col_reg;
    logic [hcr_pkg::ROW_W-1:0]    s1_row_reg;
    logic                         s1_last_reg;
    logic                         s1_hit_reg;
    logic [2*PW-1:0]              s1_fwd_reg;
    logic [2*PW-1:0]              p_rdata, p_rd, p_wdata;

    // Stage 2 registers
    logic                         s2_valid_reg;
    logic [AW-1:0]                s2_col_reg;
    logic [hcr_pkg::ROW_W-1:0]    s2_row_reg;
    logic                         s2_last_reg;
    logic [PW-1:0]                pwin_reg [9];

    // Stage 3 registers
    logic                         s3_gen_reg;
    logic signed [GW-1:0]         s3_gx_reg, s3_gy_reg;
    logic [AW-1:0]                s3_gc_reg;
    logic [AW-1:0]                s3_col_reg;
    logic [hcr_pkg::ROW_W-1:0]    s3_row_reg;
    logic                         s3_last_reg;
    logic                         s3_hit_reg;
    logic [4*GW-1:0]              s3_fwd_reg;
    logic [4*GW-1:0]              g_rdata, g_rd, g_wdata;

    logic                         gen2, hit2;
    logic [AW-1:0]                gc2;
    logic signed [GW:0]           gx_full, gy_full;

    // Gradient window and its meta
    logic signed [GW-1:0]         gwx_reg [9];
    logic signed [GW-1:0]         gwy_reg [9];
    logic                         meta_valid_reg;
    logic [hcr_pkg::COL_W-1:0]    meta_col_reg;
    logic [hcr_pkg::ROW_W-1:0]    meta_row_reg;
    logic                         meta_last_reg;

    assign acc   = in_valid && en;
    assign c0    = frame_start ? '0 : col_reg;
    assign r0    = frame_start ? '0 : row_reg;
    assign last0 = (SW'(r0) == h_eff - SW'(1)) && (SW'(c0) == w_eff - SW'(1));
    assign hit0  = s1_valid_reg && (s1_col_reg == c0);

    // Raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc)
        begin
            if (SW'(c0) + SW'(1) >= w_eff)
            begin
                col_next = '0;
                row_next = (SW'(r0) + SW'(1) >= h_eff) ? '0 : r0 + 1'b1;
            end
            else
            begin
                col_next = c0 + 1'b1;
                row_next = r0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Pixel line memory: entry = {upper line, lower line}
    hcr_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_pix_ram (
        .clk   (clk),
        .we    (en && s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (p_wdata),
        .re    (acc),
        .raddr (c0),
        .rdata (p_rdata)
    );

    // Forward the entry written in the same cycle as our read
    assign p_rd    = s1_hit_reg ? s1_fwd_reg : p_rdata;
    assign p_wdata = {p_rd[PW-1:0], s1_px_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_px_reg  <= pixel;
            s1_col_reg <= c0;
            s1_row_reg <= r0;
            s1_last_reg <= last0;
            s1_hit_reg <= hit0;
            s1_fwd_reg <= p_wdata;
        end
    end

    // Stage 1: shift the pixel window, insert the new column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                pwin_reg[i] <= '0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pwin_reg[i*3]   <= pwin_reg[i*3+1];
                    pwin_reg[i*3+1] <= pwin_reg[i*3+2];
                end
                pwin_reg[2] <= p_rd[2*PW-1:PW];
                pwin_reg[5] <= p_rd[PW-1:0];
                pwin_reg[8] <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_col_reg  <= s1_col_reg;
            s2_row_reg  <= s1_row_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 2: Sobel gradients, gradient line read
    always_comb
    begin
        gx_full = ($signed({4'b0, pwin_reg[2]}) + $signed({3'b0, pwin_reg[5], 1'b0})
                 + $signed({4'b0, pwin_reg[8]}))
                - ($signed({4'b0, pwin_reg[0]}) + $signed({3'b0, pwin_reg[3], 1'b0})
                 + $signed({4'b0, pwin_reg[6]}));
        gy_full = ($signed({4'b0, pwin_reg[6]}) + $signed({3'b0, pwin_reg[7], 1'b0})
                 + $signed({4'b0, pwin_reg[8]}))
                - ($signed({4'b0, pwin_reg[0]}) + $signed({3'b0, pwin_reg[1], 1'b0})
                 + $signed({4'b0, pwin_reg[2]}));
    end

    assign gen2 = s2_valid_reg && (s2_row_reg >= hcr_pkg::ROW_W'(2))
                  && (s2_col_reg >= AW'(2));
    assign gc2  = s2_col_reg - AW'(2);
    assign hit2 = s3_gen_reg && (s3_gc_reg == gc2);

    // Gradient line memory: entry = {upper {gx,gy}, lower {gx,gy}}
    hcr_ram #(
        .WIDTH (4 * GW),
        .DEPTH (MAX_WIDTH)
    ) u_grad_ram (
        .clk   (clk),
        .we    (en && s3_gen_reg),
        .waddr (s3_gc_reg),
        .wdata (g_wdata),
        .re    (en && gen2),
        .raddr (gc2),
        .rdata (g_rdata)
    );

    assign g_rd    = s3_hit_reg ? s3_fwd_reg : g_rdata;
    assign g_wdata = {g_rd[2*GW-1:0], s3_gx_reg, s3_gy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_gen_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_gen_reg <= gen2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_gx_reg   <= gx_full[GW-1:0];
            s3_gy_reg   <= gy_full[GW-1:0];
            s3_gc_reg   <= gc2;
            s3_col_reg  <= s2_col_reg;
            s3_row_reg  <= s2_row_reg;
            s3_last_reg <= s2_last_reg;
            s3_hit_reg  <= hit2;
            s3_fwd_reg  <= g_wdata;
        end
    end

    // Stage 3: shift the gradient window, flag windows that give a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                gwx_reg[i] <= '0;
                gwy_reg[i] <= '0;
            end
            meta_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            meta_valid_reg <= s3_gen_reg && (s3_row_reg >= hcr_pkg::ROW_W'(4))
                              && (s3_col_reg >= AW'(4));
            if (s3_gen_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    gwx_reg[i*3]   <= gwx_reg[i*3+1];
                    gwx_reg[i*3+1] <= gwx_reg[i*3+2];
                    gwy_reg[i*3]   <= gwy_reg[i*3+1];
                    gwy_reg[i*3+1] <= gwy_reg[i*3+2];
                end
                gwx_reg[2] <= g_rd[4*GW-1:3*GW];
                gwy_reg[2] <= g_rd[3*GW-1:2*GW];
                gwx_reg[5] <= g_rd[2*GW-1:GW];
                gwy_reg[5] <= g_rd[GW-1:0];
                gwx_reg[8] <= s3_gx_reg;
                gwy_reg[8] <= s3_gy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_col_reg  <= hcr_pkg::COL_W'(s3_col_reg - AW'(4));
            meta_row_reg  <= s3_row_reg - hcr_pkg::ROW_W'(4);
            meta_last_reg <= s3_last_reg;
        end
    end

    assign meta_out = {meta_valid_reg, meta_col_reg, meta_row_reg, meta_last_reg};
    assign win_gx   = gwx_reg;
    assign win_gy   = gwy_reg;

endmodule

/* rtl/core/hcr_resp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_resp
// Structure tensor sums and Harris response det - k*trace^2, saturated.
// ----------------------------------------------------------------------------
module hcr_resp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  hcr_pkg::meta_t                      meta_in,
    input  logic signed [hcr_pkg::GRAD_W-1:0]   win_gx [9],
    input  logic signed [hcr_pkg::GRAD_W-1:0]   win_gy [9],
    input  logic [hcr_pkg::K_W-1:0]             coef_k,
    output hcr_pkg::meta_t                      meta_out,
    output logic signed [hcr_pkg::RESP_W-1:0]   response
);

    // Products, sums, det terms, det/trace^2, k split, rounding, saturation
    localparam int NST = 7;
    localparam int RW  = hcr_pkg::RESP_W;

    hcr_pkg::meta_t meta_reg [NST];

    // Stage A: products
    logic signed [21:0] pxx_reg [9];
    logic signed [21:0] pxy_reg [9];
    logic signed [21:0] pyy_reg [9];
    // Stage B: sums
    logic [23:0]        sxx_reg, syy_reg;
    logic signed [24:0] sxy_reg;
    logic signed [25:0] axx, axy, ayy;
    // Stage C: det products and trace
    logic [47:0]        dxy_reg;
    logic signed [49:0] dsq_reg;
    logic [24:0]        tr_reg;
    // Stage D: det and trace squared
    logic signed [49:0] det_d_reg;
    logic [49:0]        tr2_reg;
    // Stage E: k times trace squared, split in two partial products
    logic signed [49:0] det_e_reg;
    logic [39:0]        klo_reg, khi_reg;
    // Stage F: rounded k*trace^2
    logic signed [49:0] det_f_reg;
    logic [48:0]        kt_reg;
    logic [64:0]        kt_sum;
    // Output
    logic signed [49:0] diff;
    logic signed [RW-1:0] resp_reg;

    // Meta pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                meta_reg[i] <= '0;
        end
        else if (en)
        begin
            meta_reg[0] <= meta_in;
            for (int i = 1; i < NST; i++)
                meta_reg[i] <= meta_reg[i-1];
        end
    end

    always_comb
    begin
        axx = '0;
        axy = '0;
        ayy = '0;
        for (int i = 0; i < 9; i++)
        begin
            axx = axx + 26'(pxx_reg[i]);
            axy = axy + 26'(pxy_reg[i]);
            ayy = ayy + 26'(pyy_reg[i]);
        end
    end

    assign kt_sum = ({25'd0, khi_reg} << 25) + {25'd0, klo_reg} + 65'h8000;
    assign diff   = det_f_reg - $signed({1'b0, kt_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                pxx_reg[i] <= win_gx[i] * win_gx[i];
                pxy_reg[i] <= win_gx[i] * win_gy[i];
                pyy_reg[i] <= win_gy[i] * win_gy[i];
            end
            sxx_reg   <= axx[23:0];
            syy_reg   <= ayy[23:0];
            sxy_reg   <= axy[24:0];
            dxy_reg   <= sxx_reg * syy_reg;
            dsq_reg   <= sxy_reg * sxy_reg;
            tr_reg    <= 25'(sxx_reg) + 25'(syy_reg);
            det_d_reg <= $signed({2'b0, dxy_reg}) - dsq_reg;
            tr2_reg   <= tr_reg * tr_reg;
            det_e_reg <= det_d_reg;
            klo_reg   <= coef_k * tr2_reg[24:0];
            khi_reg   <= coef_k * tr2_reg[49:25];
            det_f_reg <= det_e_reg;
            kt_reg    <= kt_sum[64:16];
            // Saturate to the 48-bit signed range
            if (diff[49:47] != 3'b000 && diff[49:47] != 3'b111)
                resp_reg <= diff[49] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
            else
                resp_reg <= diff[RW-1:0];
        end
    end

    assign meta_out = meta_reg[NST-1];
    assign response = resp_reg;

endmodule

/* rtl/core/harris_corner_response_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harris_corner_response_core
// Harris corner response of a raster gray image over a 3x3 Sobel window.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel, one beat per pixel in raster order;
//   tuser marks the first pixel of a frame and restarts the row and column
//   counters. One response leaves on m_axis for every pixel at row >= 4 and
//   column >= 4, tagged with the top-left position of its 5x5 neighborhood;
//   tlast flags the response of the last pixel of the frame.
//   Throughput is one pixel per clock while the output is not stalled.
//   The pixel line memory is read and written back once per pixel and the
//   gradient line memory once per gradient; a read of the entry written in
//   the same cycle is served by forwarding. Size and k registers are
//   written over the cfg port; the user must write them only between frames,
//   as the block does not enforce it. Reset clears counters, windows and the
//   pipeline; line memories are not cleared and need no clearing pass.
//   When the receiver holds tready low with a response waiting, the whole
//   pipeline and s_axis_tready stall.
// ----------------------------------------------------------------------------
module harris_corner_response_core #(
    parameter int MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration
    input  logic                        cfg_we,
    input  logic [hcr_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [hcr_pkg::CFG_W-1:0]   cfg_data,
    // Pixel stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] pixel
    input  logic                        s_axis_tuser,   // [0] frame_start
    // Response stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [71:0]                 m_axis_tdata,   // [47:0] response,
                                                        // [57:48] out_col,
                                                        // [69:58] out_row
    output logic                        m_axis_tlast    // frame_last
);

    logic [10:0]                  width_reg;
    logic [hcr_pkg::SIZE_W-1:0]   height_reg;
    logic [hcr_pkg::K_W-1:0]      k_reg;
    logic                         en;

    hcr_pkg::meta_t               g_meta, r_meta;
    logic signed [hcr_pkg::GRAD_W-1:0] win_gx [9];
    logic signed [hcr_pkg::GRAD_W-1:0] win_gy [9];
    logic signed [hcr_pkg::RESP_W-1:0] response;

    logic                         out_valid_reg;
    logic [71:0]                  out_data_reg;
    logic                         out_last_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= hcr_pkg::WIDTH_RST;
            height_reg <= hcr_pkg::HEIGHT_RST;
            k_reg      <= hcr_pkg::K_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hcr_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[10:0];
                hcr_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[12:0];
                hcr_pkg::CFG_COEF_K:       k_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances unless a response is held by the receiver
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    hcr_grad #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_grad (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_axis_tvalid),
        .pixel        (s_axis_tdata),
        .frame_start  (s_axis_tuser),
        .image_width  (width_reg),
        .image_height (height_reg),
        .meta_out     (g_meta),
        .win_gx       (win_gx),
        .win_gy       (win_gy)
    );

    hcr_resp u_resp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .meta_in  (g_meta),
        .win_gx   (win_gx),
        .win_gy   (win_gy),
        .coef_k   (k_reg),
        .meta_out (r_meta),
        .response (response)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= r_meta.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {2'b00, r_meta.row, r_meta.col, response};
            out_last_reg <= r_meta.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
